// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define SRFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset.
`define SRFP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/srfp_pkg.sv =====
// Shared types, constants and helpers for the sample ring / frame packer.
// No dependencies.
`timescale 1ns / 1ps

package srfp_pkg;

  // Ring and frame geometry
  localparam int unsigned RING_DEPTH  = 4096;
  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned FRAME_BYTES = 384;
  localparam int unsigned MAX_OUT     = 32;

  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned CODE_W      = 24;
  localparam int unsigned PTR_W       = $clog2(RING_DEPTH);

  // Most sets popped per drain request
  localparam int unsigned FRAME_SETS  = FRAME_BYTES / (3 * CHANNELS);
  localparam int unsigned DRAIN_LIMIT = (FRAME_SETS > MAX_OUT) ? MAX_OUT : FRAME_SETS;
  localparam int unsigned DRAIN_CNT_W = $clog2(DRAIN_LIMIT + 2);

  // Internal queue depths
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
  localparam int unsigned OUTQ_DEPTH  = 4;
  localparam int unsigned OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

  // Input function codes
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_op_e;

  typedef logic [NUM_LANES-1:0][CODE_W-1:0] chan_set_t;

  typedef struct packed {
    logic               func;
    logic signed [23:0] chan_a;
    logic signed [23:0] chan_b;
    logic signed [23:0] chan_c;
    logic signed [23:0] chan_d;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [23:0] out_a;
    logic [23:0] out_b;
    logic [23:0] out_c;
    logic [23:0] out_d;
    logic [63:0] samples_seen;
    logic [31:0] samples_lost;
    logic        last;
  } out_item_t;

  // Classified request from the front end
  typedef struct packed {
    cmd_op_e   op;
    chan_set_t chans;
  } cmd_t;

  // Next ring slot, wrapping at the ring depth
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== rtl/srfp_front.sv =====
// Front end: accepts input requests, classifies them and masks unused lanes.
// Depends on srfp_pkg.
`timescale 1ns / 1ps

module srfp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  srfp_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  output srfp_pkg::cmd_t     cmd_o,
  input  logic               cmdq_full_i
);

  logic           valid_q, valid_d;
  srfp_pkg::cmd_t cmd_q, cmd_d;
  logic           take;
  logic           fwd;
  srfp_pkg::chan_set_t raw;

  // Hand the held request on whenever the command queue has room
  assign fwd  = valid_q && !cmdq_full_i;
  assign full = valid_q && cmdq_full_i;
  assign take = push && !full;

  // Classify and keep only the configured channels
  always_comb begin
    raw[0] = in_data_i.chan_a;
    raw[1] = in_data_i.chan_b;
    raw[2] = in_data_i.chan_c;
    raw[3] = in_data_i.chan_d;
    cmd_d.op = (in_data_i.func == srfp_pkg::FUNC_DRAIN) ? srfp_pkg::CMD_DRAIN
                                                          : srfp_pkg::CMD_PUSH;
    for (int j = 0; j < srfp_pkg::NUM_LANES; j++) begin
      cmd_d.chans[j] = (j < srfp_pkg::CHANNELS) ? raw[j] : '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fwd) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== rtl/srfp_cmd_q.sv =====
// Short request queue between the front end and the back end.
// Depends on srfp_pkg.
`timescale 1ns / 1ps

module srfp_cmd_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  srfp_pkg::cmd_t wr_cmd_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           valid_o,
  output srfp_pkg::cmd_t rd_cmd_o
);

  srfp_pkg::cmd_t                    slot_q [srfp_pkg::CMDQ_DEPTH];
  logic [srfp_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [srfp_pkg::CMDQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                              do_wr, do_rd;

  assign full_o   = (cnt_q == srfp_pkg::CMDQ_CNT_W'(srfp_pkg::CMDQ_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && valid_o;
  assign rd_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == srfp_pkg::CMDQ_PTR_W'(srfp_pkg::CMDQ_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == srfp_pkg::CMDQ_PTR_W'(srfp_pkg::CMDQ_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== rtl/srfp_back.sv =====
// Back end: sample ring memory, counters, drain sequencer and result queue.
// Depends on srfp_pkg.
`timescale 1ns / 1ps

module srfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  srfp_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output srfp_pkg::out_item_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e                           state_q, state_d;
  logic [srfp_pkg::DRAIN_CNT_W-1:0] left_q, left_d;
  logic [srfp_pkg::PTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [srfp_pkg::PTR_W-1:0]       wr_nxt, rd_nxt;
  logic [63:0]                      seen_q, seen_d;
  logic [31:0]                      lost_q, lost_d;
  logic                             ring_full, ring_empty;
  logic                             room, mem_we, mem_re, drain_last;

  // Result stage: metadata beside the registered memory read
  logic                             res_valid_q, res_valid_d;
  srfp_pkg::out_item_t              res_q, res_d;
  srfp_pkg::chan_set_t              rdata_q;
  srfp_pkg::out_item_t              res_full;

  // Ring storage
  srfp_pkg::chan_set_t              mem_q [srfp_pkg::RING_DEPTH];

  // Result queue
  srfp_pkg::out_item_t              outq_q [srfp_pkg::OUTQ_DEPTH];
  logic [srfp_pkg::OUTQ_PTR_W-1:0]  oq_wr_q, oq_rd_q;
  logic [srfp_pkg::OUTQ_CNT_W-1:0]  oq_cnt_q, oq_cnt_d;
  logic                             oq_pop;

  assign wr_nxt     = srfp_pkg::ptr_next(wr_ptr_q);
  assign rd_nxt     = srfp_pkg::ptr_next(rd_ptr_q);
  assign ring_full  = (wr_nxt == rd_ptr_q);
  assign ring_empty = (wr_ptr_q == rd_ptr_q);

  // Issue only when the result queue can absorb the entry in flight too
  assign room = (oq_cnt_q + srfp_pkg::OUTQ_CNT_W'(res_valid_q))
                < srfp_pkg::OUTQ_CNT_W'(srfp_pkg::OUTQ_DEPTH);

  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i && room;
  assign drain_last = (left_q == srfp_pkg::DRAIN_CNT_W'(1)) || (rd_nxt == wr_ptr_q);

  // Request execution and drain sequencing
  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    seen_d      = seen_q;
    lost_d      = lost_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          if (cmd_i.op == srfp_pkg::CMD_PUSH) begin
            seen_d = seen_q + 64'd1;
            if (ring_full) begin
              lost_d = lost_q + 32'd1;
            end else begin
              mem_we   = 1'b1;
              wr_ptr_d = wr_nxt;
            end
            res_valid_d        = 1'b1;
            res_d.kind         = srfp_pkg::KIND_STATUS;
            res_d.accepted     = !ring_full;
            res_d.samples_seen = seen_d;
            res_d.samples_lost = lost_d;
            res_d.last         = 1'b1;
          end else if (!ring_empty && (srfp_pkg::DRAIN_LIMIT != 0)) begin
            state_d = ST_DRAIN;
            left_d  = srfp_pkg::DRAIN_CNT_W'(srfp_pkg::DRAIN_LIMIT);
          end
        end
      end
      ST_DRAIN: begin
        if (room) begin
          mem_re             = 1'b1;
          rd_ptr_d           = rd_nxt;
          left_d             = left_q - 1'b1;
          res_valid_d        = 1'b1;
          res_d.kind         = srfp_pkg::KIND_SAMPLE;
          res_d.samples_seen = seen_q;
          res_d.samples_lost = lost_q;
          res_d.last         = drain_last;
          if (drain_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      seen_q      <= '0;
      lost_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      seen_q      <= seen_d;
      lost_q      <= lost_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Ring memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= cmd_i.chans;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  // Merge read data into sample results
  always_comb begin
    res_full = res_q;
    if (res_q.kind == srfp_pkg::KIND_SAMPLE) begin
      res_full.out_a = rdata_q[0];
      res_full.out_b = rdata_q[1];
      res_full.out_c = rdata_q[2];
      res_full.out_d = rdata_q[3];
    end
  end

  // Result queue
  assign empty      = (oq_cnt_q == '0);
  assign oq_pop     = pop && !empty;
  assign out_data_o = outq_q[oq_rd_q];

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (res_valid_q && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (oq_pop && !res_valid_q) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (res_valid_q) begin
        oq_wr_q <= (oq_wr_q == srfp_pkg::OUTQ_PTR_W'(srfp_pkg::OUTQ_DEPTH - 1))
                   ? '0 : oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= (oq_rd_q == srfp_pkg::OUTQ_PTR_W'(srfp_pkg::OUTQ_DEPTH - 1))
                   ? '0 : oq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_q) begin
      outq_q[oq_wr_q] <= res_full;
    end
  end

endmodule

// ===== rtl/sample_ring_with_frame_packer_unit.sv =====
// Top level of the sample ring with frame packer.
// Depends on srfp_pkg, srfp_front, srfp_cmd_q and srfp_back.
`timescale 1ns / 1ps

// Sample FIFO between a four-channel converter and a packet link, queue-like
// on both sides. A push request (func 0) stores one sample set unless the ring
// is full (4095 usable slots) and always yields one status result with the
// updated offered and lost counts. A drain request (func 1) pops up to 32 sets,
// one result each, the final one flagged last; an empty ring yields nothing.
// Pushes are taken one per cycle when results are drained as fast. A drain
// enters its drain state, then reads its sets in turn, each read held while
// the result queue lacks room. A request passes the front-end register, the
// request queue and the result stage to the result queue, whose head is on
// the result ports. The ring memory needs no initialization after reset.

module sample_ring_with_frame_packer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  srfp_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output srfp_pkg::out_item_t out_data_o
);

  logic           fe_valid;
  srfp_pkg::cmd_t fe_cmd;
  logic           cq_full;
  logic           cq_valid;
  srfp_pkg::cmd_t cq_cmd;
  logic           cq_pop;

  // Request intake and classification
  srfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (fe_valid),
    .cmd_o       (fe_cmd),
    .cmdq_full_i (cq_full)
  );

  // Decoupling queue
  srfp_cmd_q u_cmd_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (fe_valid),
    .wr_cmd_i (fe_cmd),
    .full_o   (cq_full),
    .rd_en_i  (cq_pop),
    .valid_o  (cq_valid),
    .rd_cmd_o (cq_cmd)
  );

  // Ring, counters and result delivery
  srfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cq_valid),
    .cmd_i       (cq_cmd),
    .cmd_pop_o   (cq_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/srfp_checker.sv =====
// Port-level checker for the sample ring with frame packer, bound to the top.
// Depends on srfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srfp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input srfp_pkg::out_item_t out_data_o
);

  logic status_shown;
  logic sample_shown;

  // Kind of the result currently on the ports
  assign status_shown = !empty && (out_data_o.kind == srfp_pkg::KIND_STATUS);
  assign sample_shown = !empty && (out_data_o.kind == srfp_pkg::KIND_SAMPLE);

  // Status results end their request
  `SRFP_ASSERT(a_status_last, clk_i, rst_ni, status_shown |-> out_data_o.last)

  // Drained sets never report a store
  `SRFP_ASSERT(a_sample_not_acc, clk_i, rst_ni, sample_shown |-> !out_data_o.accepted)

  // A waiting result holds until taken
  `SRFP_ASSERT(a_result_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_data_o)))

  // Nothing pending and no backpressure once a reset edge has passed
  `SRFP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> (empty && !full))

endmodule

bind sample_ring_with_frame_packer_unit srfp_checker u_srfp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);
